FILE: hw/rtl/ucfp_pkg.sv
// Shared types and constants for the UART command frame parser.
// No dependencies; every other file of the block depends on this package.
package ucfp_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned VALUE_W  = 32;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned ACTION_W = 2;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned PHASE_W  = 3;
    localparam int unsigned COUNT_W  = 3;

    typedef logic [BYTE_W-1:0]    t_byte;
    typedef logic [VALUE_W-1:0]   t_value;
    typedef logic [STATUS_W-1:0]  t_status;
    typedef logic [ACTION_W-1:0]  t_action;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    typedef logic [PHASE_W-1:0]   t_phase;
    typedef logic [COUNT_W-1:0]   t_count;

    // Parse phases.
    localparam t_phase PH_HUNT = 3'd0;
    localparam t_phase PH_RATE = 3'd1;
    localparam t_phase PH_AVG  = 3'd2;
    localparam t_phase PH_RUN  = 3'd3;
    localparam t_phase PH_TAIL = 3'd4;

    // Frame status codes.
    localparam t_status ST_OK        = 2'd0;
    localparam t_status ST_RATE_HIGH = 2'd1;
    localparam t_status ST_AVG_HIGH  = 2'd2;

    // Frame action codes.
    localparam t_action ACT_NONE  = 2'd0;
    localparam t_action ACT_STORE = 2'd1;
    localparam t_action ACT_STOP  = 2'd2;
    localparam t_action ACT_START = 2'd3;

    // Configuration register indexes.
    localparam t_cfg_idx REG_HEADER   = 3'd0;
    localparam t_cfg_idx REG_TAIL     = 3'd1;
    localparam t_cfg_idx REG_STOP     = 3'd2;
    localparam t_cfg_idx REG_START    = 3'd3;
    localparam t_cfg_idx REG_MAX_RATE = 3'd4;

    // Reset values of the configuration registers.
    localparam t_byte  HEADER_RST   = 8'hAA;
    localparam t_byte  TAIL_RST     = 8'h55;
    localparam t_byte  STOP_RST     = 8'h00;
    localparam t_byte  START_RST    = 8'h01;
    localparam t_value MAX_RATE_RST = 32'd300000;

    localparam t_byte  STORE_CODE      = 8'hFF;
    localparam t_count BYTES_PER_VALUE = 3'd4;

    // Configuration as seen by the frame classifier.
    typedef struct packed {
        t_byte  stop_code;
        t_byte  start_code;
        t_value max_sample_rate;
    } t_class_cfg;

    // Verdict of the classifier.
    typedef struct packed {
        t_status frame_status;
        t_action frame_action;
    } t_verdict;

endpackage

FILE: hw/rtl/ucfp_if.sv
// Handshake channel interfaces of the UART command frame parser.
// Depends on ucfp_pkg.
interface ucfp_byte_if;
    logic           valid;
    logic           ready;
    ucfp_pkg::t_byte rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface ucfp_frame_if;
    logic              valid;
    logic              ready;
    ucfp_pkg::t_value  sample_rate;
    ucfp_pkg::t_value  average_count;
    ucfp_pkg::t_byte   run_code;
    ucfp_pkg::t_status frame_status;
    ucfp_pkg::t_action frame_action;

    modport source (output valid, output sample_rate, output average_count,
                    output run_code, output frame_status, output frame_action,
                    input ready);
    modport sink   (input valid, input sample_rate, input average_count,
                    input run_code, input frame_status, input frame_action,
                    output ready);
endinterface

interface ucfp_cfg_if;
    logic               valid;
    logic               ready;
    ucfp_pkg::t_cfg_idx index;
    ucfp_pkg::t_value   data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: hw/rtl/ucfp_classify.sv
// Frame classifier: status checks and action decode for a completed frame.
// Depends on ucfp_pkg.
module ucfp_classify (
    input  ucfp_pkg::t_value     i_sample_rate,
    input  ucfp_pkg::t_value     i_average_count,
    input  ucfp_pkg::t_byte      i_run_code,
    input  ucfp_pkg::t_class_cfg i_cfg,
    output ucfp_pkg::t_verdict   o_verdict
);
    import ucfp_pkg::*;

    t_status status;
    t_action action;

    // The rate check wins when both checks fail.
    always_comb begin
        if (i_sample_rate > i_cfg.max_sample_rate) begin
            status = ST_RATE_HIGH;
        end else if (i_average_count > i_sample_rate) begin
            status = ST_AVG_HIGH;
        end else begin
            status = ST_OK;
        end
    end

    // Store beats stop, stop beats start when the codes overlap.
    always_comb begin
        if (status != ST_OK) begin
            action = ACT_NONE;
        end else if (i_run_code == STORE_CODE) begin
            action = ACT_STORE;
        end else if (i_run_code == i_cfg.stop_code) begin
            action = ACT_STOP;
        end else if (i_run_code == i_cfg.start_code) begin
            action = ACT_START;
        end else begin
            action = ACT_NONE;
        end
    end

    assign o_verdict.frame_status = status;
    assign o_verdict.frame_action = action;

endmodule

FILE: hw/rtl/uart_command_frame_parser_unit.sv
// Top level of the UART command frame parser: input register, frame state
// machine, configuration registers and result register.
// Depends on ucfp_pkg, ucfp_if and ucfp_classify.
//
//   channel    dir   payload                                   accepted when
//   i_byte     in    rx_byte                                   valid & ready
//   i_cfg      in    index, data                               valid & ready
//   o_frame    out   sample_rate, average_count, run_code,     valid & ready
//                    frame_status, frame_action
//
// A byte is registered on acceptance and parsed from the input register; a good
// tail byte loads the result register, which presents the frame. One byte per
// cycle is sustained unless a tail waits as described next. Only a tail byte
// that completes a frame can wait on a full result register, and then the
// input register holds it and i_byte.ready falls. Configuration writes are
// always ready. Reset returns the parser to header hunting and loads the
// default configuration.
module uart_command_frame_parser_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ucfp_byte_if.sink   i_byte,
    ucfp_cfg_if.sink    i_cfg,
    ucfp_frame_if.source o_frame
);
    import ucfp_pkg::*;

    // Configuration registers.
    t_byte  r_header;
    t_byte  r_tail;
    t_byte  r_stop;
    t_byte  r_start;
    t_value r_max_rate;

    // Input register.
    logic  r_in_valid;
    t_byte r_in_byte;

    // Parser state.
    t_phase r_phase, n_phase;
    t_count r_count, n_count;
    t_value r_rate, n_rate;
    t_value r_avg, n_avg;
    t_byte  r_run, n_run;

    // Result register.
    logic     r_out_valid;
    t_value   r_out_rate;
    t_value   r_out_avg;
    t_byte    r_out_run;
    t_verdict r_out_verdict;

    t_class_cfg class_cfg;
    t_verdict   verdict;
    t_count     count_inc;
    logic       frame_done;
    logic       out_free;
    logic       parse_fire;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header   <= HEADER_RST;
            r_tail     <= TAIL_RST;
            r_stop     <= STOP_RST;
            r_start    <= START_RST;
            r_max_rate <= MAX_RATE_RST;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_HEADER:   r_header   <= i_cfg.data[BYTE_W-1:0];
                REG_TAIL:     r_tail     <= i_cfg.data[BYTE_W-1:0];
                REG_STOP:     r_stop     <= i_cfg.data[BYTE_W-1:0];
                REG_START:    r_start    <= i_cfg.data[BYTE_W-1:0];
                REG_MAX_RATE: r_max_rate <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // A good tail needs a free result slot; every other byte moves on at once.
    assign frame_done = (r_phase == PH_TAIL) && (r_in_byte == r_tail);
    assign out_free   = !r_out_valid || o_frame.ready;
    assign parse_fire = r_in_valid && (!frame_done || out_free);
    assign i_byte.ready = !r_in_valid || parse_fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_byte.ready) begin
            r_in_valid <= i_byte.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_byte.ready && i_byte.valid) begin
            r_in_byte <= i_byte.rx_byte;
        end
    end

    assign count_inc = r_count + COUNT_W'(1);

    always_comb begin
        n_phase = r_phase;
        n_count = r_count;
        n_rate  = r_rate;
        n_avg   = r_avg;
        n_run   = r_run;
        case (r_phase)
            PH_HUNT: begin
                if (r_in_byte == r_header) begin
                    n_count = '0;
                    n_rate  = '0;
                    n_phase = PH_RATE;
                end
            end
            PH_RATE: begin
                n_rate  = {r_rate[VALUE_W-BYTE_W-1:0], r_in_byte};
                n_count = count_inc;
                if (count_inc >= BYTES_PER_VALUE) begin
                    n_count = '0;
                    n_avg   = '0;
                    n_phase = PH_AVG;
                end
            end
            PH_AVG: begin
                n_avg   = {r_avg[VALUE_W-BYTE_W-1:0], r_in_byte};
                n_count = count_inc;
                if (count_inc >= BYTES_PER_VALUE) begin
                    n_count = '0;
                    n_phase = PH_RUN;
                end
            end
            PH_RUN: begin
                n_run   = r_in_byte;
                n_phase = PH_TAIL;
            end
            default: begin
                // The tail phase and any unreachable code end in hunting.
                n_phase = PH_HUNT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HUNT;
            r_count <= '0;
            r_rate  <= '0;
            r_avg   <= '0;
            r_run   <= '0;
        end else if (parse_fire) begin
            r_phase <= n_phase;
            r_count <= n_count;
            r_rate  <= n_rate;
            r_avg   <= n_avg;
            r_run   <= n_run;
        end
    end

    assign class_cfg.stop_code       = r_stop;
    assign class_cfg.start_code      = r_start;
    assign class_cfg.max_sample_rate = r_max_rate;

    ucfp_classify u_classify (
        .i_sample_rate   (r_rate),
        .i_average_count (r_avg),
        .i_run_code      (r_run),
        .i_cfg           (class_cfg),
        .o_verdict       (verdict)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (parse_fire && frame_done) begin
            r_out_valid <= 1'b1;
        end else if (o_frame.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (parse_fire && frame_done) begin
            r_out_rate    <= r_rate;
            r_out_avg     <= r_avg;
            r_out_run     <= r_run;
            r_out_verdict <= verdict;
        end
    end

    assign o_frame.valid         = r_out_valid;
    assign o_frame.sample_rate   = r_out_rate;
    assign o_frame.average_count = r_out_avg;
    assign o_frame.run_code      = r_out_run;
    assign o_frame.frame_status  = r_out_verdict.frame_status;
    assign o_frame.frame_action  = r_out_verdict.frame_action;

endmodule

FILE: verif/testbench.sv
// Self-checking testbench for uart_command_frame_parser_unit.
// Sends byte streams of well-formed, broken and noisy command frames under several
// register settings and checks every decoded frame. Depends on ucfp_pkg and ucfp_if.
module testbench;
    import ucfp_pkg::*;

    localparam int unsigned CLK_PERIOD   = 12;
    localparam int unsigned MAX_IDLE     = 19;
    localparam int unsigned PHASE_ITEMS  = 160;
    localparam int unsigned DRAIN_CYCLES = 4;
    localparam int unsigned REPORT_LIMIT = 10;

    typedef struct {
        t_byte       value;
        int unsigned gap;
    } t_rx_item;

    typedef struct {
        t_value  sample_rate;
        t_value  average_count;
        t_byte   run_code;
        t_status frame_status;
        t_action frame_action;
    } t_frame;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    ucfp_byte_if  rx_chan();
    ucfp_cfg_if   cfg_chan();
    ucfp_frame_if frame_chan();

    uart_command_frame_parser_unit DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_byte  (rx_chan),
        .i_cfg   (cfg_chan),
        .o_frame (frame_chan)
    );

    always begin
        #(CLK_PERIOD / 2) i_clk = 1'b1;
        #(CLK_PERIOD / 2) i_clk = 1'b0;
    end

    // Register copies and parser state of the predictor.
    t_byte  cfg_header   = HEADER_RST;
    t_byte  cfg_tail     = TAIL_RST;
    t_byte  cfg_stop     = STOP_RST;
    t_byte  cfg_start    = START_RST;
    t_value cfg_max_rate = MAX_RATE_RST;

    t_phase parse_phase  = PH_HUNT;
    t_count byte_cnt     = '0;
    t_value rate_acc     = '0;
    t_value avg_acc      = '0;
    t_byte  run_hold     = '0;

    t_rx_item    pending[$];
    t_frame      frames_due[$];
    int unsigned rx_queued      = 0;
    int unsigned rx_accepted    = 0;
    int unsigned mismatch_count = 0;
    int unsigned phase_items    = 0;
    bit          src_calm       = 1'b0;
    bit          sink_calm      = 1'b0;

    // Advance the frame parser by one byte; a good tail yields a decoded frame.
    task automatic absorb_rx_byte(input t_byte b);
        t_frame f;
        case (parse_phase)
            PH_HUNT: begin
                if (b == cfg_header) begin
                    byte_cnt    = '0;
                    rate_acc    = '0;
                    parse_phase = PH_RATE;
                end
            end
            PH_RATE: begin
                rate_acc = {rate_acc[VALUE_W-BYTE_W-1:0], b};
                byte_cnt = byte_cnt + COUNT_W'(1);
                if (byte_cnt >= BYTES_PER_VALUE) begin
                    byte_cnt    = '0;
                    avg_acc     = '0;
                    parse_phase = PH_AVG;
                end
            end
            PH_AVG: begin
                avg_acc  = {avg_acc[VALUE_W-BYTE_W-1:0], b};
                byte_cnt = byte_cnt + COUNT_W'(1);
                if (byte_cnt >= BYTES_PER_VALUE) begin
                    byte_cnt    = '0;
                    parse_phase = PH_RUN;
                end
            end
            PH_RUN: begin
                run_hold    = b;
                parse_phase = PH_TAIL;
            end
            PH_TAIL: begin
                parse_phase = PH_HUNT;
                if (b == cfg_tail) begin
                    f.sample_rate   = rate_acc;
                    f.average_count = avg_acc;
                    f.run_code      = run_hold;
                    // The rate check wins when both limits are broken.
                    if (rate_acc > cfg_max_rate)
                        f.frame_status = ST_RATE_HIGH;
                    else if (avg_acc > rate_acc)
                        f.frame_status = ST_AVG_HIGH;
                    else
                        f.frame_status = ST_OK;
                    if (f.frame_status != ST_OK)
                        f.frame_action = ACT_NONE;
                    else if (run_hold == STORE_CODE)
                        f.frame_action = ACT_STORE;
                    else if (run_hold == cfg_stop)
                        f.frame_action = ACT_STOP;
                    else if (run_hold == cfg_start)
                        f.frame_action = ACT_START;
                    else
                        f.frame_action = ACT_NONE;
                    frames_due.push_back(f);
                end
            end
            default: parse_phase = PH_HUNT;
        endcase
    endtask

    // Byte sender.
    int unsigned idle_cnt = 0;
    t_rx_item    next_rx;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rx_chan.valid <= 1'b0;
            idle_cnt = 0;
        end else begin
            if (rx_chan.valid && rx_chan.ready) begin
                absorb_rx_byte(rx_chan.rx_byte);
                rx_accepted++;
            end
            if (!rx_chan.valid || rx_chan.ready) begin
                if (pending.size() != 0 && idle_cnt >= pending[0].gap) begin
                    next_rx = pending.pop_front();
                    rx_chan.valid   <= 1'b1;
                    rx_chan.rx_byte <= next_rx.value;
                    idle_cnt = 0;
                end else begin
                    rx_chan.valid <= 1'b0;
                    if (pending.size() != 0)
                        idle_cnt++;
                end
            end
        end
    end

    task automatic flag_mismatch(input string field, input t_value want_v, input t_value got_v);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
            $display("Mismatch on %s: expected %0h, got %0h", field, want_v, got_v);
    endtask

    // Frame receiver and checker.
    int unsigned sink_hold = 0;
    t_frame      want;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            frame_chan.ready <= 1'b0;
            sink_hold = 0;
        end else begin
            if (frame_chan.valid && frame_chan.ready) begin
                if (frames_due.size() == 0) begin
                    flag_mismatch("unexpected frame, sample_rate", '0, frame_chan.sample_rate);
                end else begin
                    want = frames_due.pop_front();
                    if (frame_chan.sample_rate !== want.sample_rate)
                        flag_mismatch("sample_rate", want.sample_rate, frame_chan.sample_rate);
                    if (frame_chan.average_count !== want.average_count)
                        flag_mismatch("average_count", want.average_count,
                                      frame_chan.average_count);
                    if (frame_chan.run_code !== want.run_code)
                        flag_mismatch("run_code", want.run_code, frame_chan.run_code);
                    if (frame_chan.frame_status !== want.frame_status)
                        flag_mismatch("frame_status", want.frame_status,
                                      frame_chan.frame_status);
                    if (frame_chan.frame_action !== want.frame_action)
                        flag_mismatch("frame_action", want.frame_action,
                                      frame_chan.frame_action);
                end
                sink_hold = sink_calm ? 0 : $urandom_range(0, MAX_IDLE);
            end else if (sink_hold > 0) begin
                sink_hold--;
            end
            frame_chan.ready <= (sink_hold == 0);
        end
    end

    task automatic push_rx(input t_byte b);
        t_rx_item it;
        it.value = b;
        it.gap   = src_calm ? 0 : $urandom_range(0, MAX_IDLE);
        pending.push_back(it);
        rx_queued++;
        phase_items++;
    endtask

    task automatic push_frame(input t_value rate, input t_value avg, input t_byte run,
                              input t_byte tail);
        push_rx(cfg_header);
        for (int k = VALUE_W / BYTE_W - 1; k >= 0; k--)
            push_rx(rate[k*BYTE_W +: BYTE_W]);
        for (int k = VALUE_W / BYTE_W - 1; k >= 0; k--)
            push_rx(avg[k*BYTE_W +: BYTE_W]);
        push_rx(run);
        push_rx(tail);
    endtask

    task automatic push_random_frame();
        t_value rate;
        t_value avg;
        t_byte  run;
        t_byte  tail;
        t_byte  junk;
        // Noise between frames; the parser only looks for a header here.
        repeat ($urandom_range(0, 2)) begin
            junk = t_byte'($urandom_range(0, 255));
            if (junk == cfg_header && $urandom_range(0, 3) != 0)
                junk = ~junk;
            push_rx(junk);
        end
        // Now and then a frame is cut short and the next one runs into it.
        if ($urandom_range(0, 9) == 0) begin
            push_rx(cfg_header);
            repeat ($urandom_range(1, 10)) push_rx(t_byte'($urandom_range(0, 255)));
        end
        case ($urandom_range(0, 3))
            0: rate = $urandom();
            1: rate = cfg_max_rate + $urandom_range(0, 2) - 1;
            2: rate = $urandom_range(0, cfg_max_rate);
            default: rate = $urandom_range(0, 1) ? '1 : '0;
        endcase
        case ($urandom_range(0, 3))
            0: avg = rate;
            1: avg = rate + 1;
            2: avg = $urandom_range(0, rate);
            default: avg = $urandom();
        endcase
        case ($urandom_range(0, 3))
            0: run = cfg_stop;
            1: run = cfg_start;
            2: run = STORE_CODE;
            default: run = t_byte'($urandom_range(0, 255));
        endcase
        if ($urandom_range(0, 99) < 85) begin
            tail = cfg_tail;
        end else begin
            tail = ($urandom_range(0, 2) == 0) ? cfg_header : t_byte'($urandom_range(0, 255));
            if (tail == cfg_tail)
                tail = ~tail;
        end
        push_frame(rate, avg, run, tail);
        if ($urandom_range(0, 9) == 0)
            src_calm = !src_calm;
        if ($urandom_range(0, 9) == 0)
            sink_calm = !sink_calm;
    endtask

    task automatic fill_random_phase();
        while (phase_items < PHASE_ITEMS)
            push_random_frame();
    endtask

    // Waits until all bytes are taken and all frames checked, then lets the
    // pipeline settle, since a bad tail leaves no frame to wait for.
    task automatic wait_drained();
        while (rx_accepted != rx_queued || frames_due.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        phase_items = 0;
        src_calm    = ($urandom_range(0, 3) == 0);
        sink_calm   = ($urandom_range(0, 3) == 0);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input t_value val);
        @(posedge i_clk);
        cfg_chan.valid <= 1'b1;
        cfg_chan.index <= idx;
        cfg_chan.data  <= val;
        do @(posedge i_clk); while (!cfg_chan.ready);
        case (idx)
            REG_HEADER:   cfg_header   = val[BYTE_W-1:0];
            REG_TAIL:     cfg_tail     = val[BYTE_W-1:0];
            REG_STOP:     cfg_stop     = val[BYTE_W-1:0];
            REG_START:    cfg_start    = val[BYTE_W-1:0];
            REG_MAX_RATE: cfg_max_rate = val;
            default: ;
        endcase
        cfg_chan.valid <= 1'b0;
    endtask

    initial begin
        t_byte shared_code;
        rx_chan.valid    = 1'b0;
        rx_chan.rx_byte  = '0;
        cfg_chan.valid   = 1'b0;
        cfg_chan.index   = REG_HEADER;
        cfg_chan.data    = '0;
        frame_chan.ready = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings: rate exactly at the limit, both limits broken at
        // once, and a bad tail equal to the header followed by a good frame.
        push_frame(MAX_RATE_RST, MAX_RATE_RST, STORE_CODE, TAIL_RST);
        push_frame(MAX_RATE_RST + 1, '1, START_RST, TAIL_RST);
        push_frame(32'd1000, 32'd1001, STOP_RST, TAIL_RST);
        push_frame(32'd5, 32'd5, START_RST, HEADER_RST);
        push_frame(32'd7, 32'd0, STOP_RST, TAIL_RST);
        fill_random_phase();
        wait_drained();

        // Extremes: stop and start both equal the store code.
        write_reg(REG_HEADER, 32'h00);
        write_reg(REG_TAIL, 32'hFF);
        write_reg(REG_STOP, 32'hFF);
        write_reg(REG_START, 32'hFF);
        write_reg(REG_MAX_RATE, '1);
        push_frame('1, '0, STORE_CODE, cfg_tail);
        push_frame('1, '1, 8'h00, cfg_tail);
        fill_random_phase();
        wait_drained();

        // Opposite extremes, stop equal to start, and writes to unused
        // indexes that must change nothing.
        write_reg(REG_HEADER, 32'hFF);
        write_reg(REG_TAIL, 32'h00);
        write_reg(REG_STOP, 32'h5A);
        write_reg(REG_START, 32'h5A);
        write_reg(REG_MAX_RATE, '0);
        for (int k = REG_MAX_RATE + 1; k < 2 ** CFG_IDX_W; k++)
            write_reg(t_cfg_idx'(k), $urandom());
        push_frame('0, '0, 8'h5A, cfg_tail);
        push_frame(32'd1, '0, 8'h5A, cfg_tail);
        fill_random_phase();
        wait_drained();

        repeat (6) begin
            write_reg(REG_HEADER, $urandom_range(0, 255));
            write_reg(REG_TAIL, $urandom_range(0, 255));
            shared_code = t_byte'($urandom_range(0, 255));
            write_reg(REG_STOP, t_value'(shared_code));
            write_reg(REG_START, ($urandom_range(0, 3) == 0) ? t_value'(shared_code)
                                                             : $urandom_range(0, 255));
            case ($urandom_range(0, 2))
                0: write_reg(REG_MAX_RATE, $urandom());
                1: write_reg(REG_MAX_RATE, $urandom_range(0, 1000));
                default: write_reg(REG_MAX_RATE, MAX_RATE_RST);
            endcase
            if ($urandom_range(0, 2) == 0)
                write_reg(t_cfg_idx'($urandom_range(REG_MAX_RATE + 1, 2 ** CFG_IDX_W - 1)),
                          $urandom());
            fill_random_phase();
            wait_drained();
        end

        repeat (10) @(posedge i_clk);
        if (mismatch_count == 0 && frames_due.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial begin
        #(CLK_PERIOD * 400000);
        $display("TEST FAILED");
        $finish;
    end

endmodule
